FILE: rtl/positional_list_insert_delete_assert.svh
// assertion macros for the positional list
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PLST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define PLST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/plst_pkg.sv
`timescale 1ns / 1ps
package plst_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned PosW        = 5;
  localparam int unsigned ValW        = 32;
  localparam int unsigned LenW        = 5;

  localparam logic ReqInsert = 1'b0;
  localparam logic ReqDelete = 1'b1;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBadPos = 2'd1,
    StFull   = 2'd2
  } plst_status_e;

  typedef struct packed {
    logic            ins;
    logic            del;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] value;
  } plst_op_t;

endpackage

FILE: rtl/plst_ctrl.sv
`timescale 1ns / 1ps
module plst_ctrl #(
  parameter int unsigned Capacity = plst_pkg::DefCapacity,
  localparam int unsigned CntW = $clog2(Capacity + 1)
) (
  input  logic                      accept_i,
  input  logic                      req_type_i,
  input  logic [plst_pkg::PosW-1:0] position_i,
  input  logic [plst_pkg::ValW-1:0] new_value_i,
  input  logic [CntW-1:0]           count_i,
  output plst_pkg::plst_op_t        op_o,
  output plst_pkg::plst_status_e    status_o
);

  localparam int unsigned CmpW = ((CntW > plst_pkg::PosW) ? CntW : plst_pkg::PosW) + 1;

  logic [CmpW-1:0] pos_x;
  logic [CmpW-1:0] cnt_x;
  logic            pos_zero;

  assign pos_x    = CmpW'(position_i);
  assign cnt_x    = CmpW'(count_i);
  assign pos_zero = (position_i == '0);

  always_comb begin
    status_o = plst_pkg::StOk;
    unique case (req_type_i)
      plst_pkg::ReqInsert: begin
        if (pos_zero || (pos_x > cnt_x + CmpW'(1))) begin
          status_o = plst_pkg::StBadPos;
        end else if (cnt_x == CmpW'(Capacity)) begin
          status_o = plst_pkg::StFull;
        end
      end
      default: begin
        if (pos_zero || (pos_x > cnt_x)) begin
          status_o = plst_pkg::StBadPos;
        end
      end
    endcase
  end

  always_comb begin
    op_o.ins   = accept_i && (status_o == plst_pkg::StOk) && (req_type_i == plst_pkg::ReqInsert);
    op_o.del   = accept_i && (status_o == plst_pkg::StOk) && (req_type_i == plst_pkg::ReqDelete);
    op_o.pos   = position_i;
    op_o.value = new_value_i;
  end

endmodule

FILE: rtl/plst_cell.sv
`timescale 1ns / 1ps
module plst_cell #(
  parameter int unsigned Capacity = plst_pkg::DefCapacity,
  parameter int unsigned Idx      = 0
) (
  input  logic                      clk_i,
  input  plst_pkg::plst_op_t        op_i,
  input  logic [plst_pkg::ValW-1:0] left_i,
  input  logic [plst_pkg::ValW-1:0] right_i,
  output logic [plst_pkg::ValW-1:0] value_o
);

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CmpW = ((IdxW > plst_pkg::PosW) ? IdxW : plst_pkg::PosW) + 1;
  localparam logic [CmpW-1:0] IdxV = CmpW'(Idx);

  logic [CmpW-1:0]           pos0;
  logic [plst_pkg::ValW-1:0] value_d;
  logic [plst_pkg::ValW-1:0] value_q;

  assign pos0 = CmpW'(op_i.pos) - CmpW'(1);

  always_comb begin
    value_d = value_q;
    if (op_i.ins) begin
      if (IdxV == pos0) begin
        value_d = op_i.value;
      end else if (IdxV > pos0) begin
        value_d = left_i;
      end
    end else if (op_i.del && (IdxV >= pos0)) begin
      value_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: rtl/positional_list_insert_delete.sv
`timescale 1ns / 1ps
// the response to a request accepted in one cycle is registered and valid from the next cycle
// throughput: one request per cycle while responses are taken; every cell shifts in the same cycle as the decode
// the response register frees as it is taken, so a new request enters alongside
// reset: list count and response valid cleared; cell contents and response fields are not reset
`include "positional_list_insert_delete_assert.svh"
module positional_list_insert_delete #(
  parameter int unsigned Capacity = plst_pkg::DefCapacity
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  logic                             req_type_i,
  input  logic [plst_pkg::PosW-1:0]        position_i,
  input  logic signed [plst_pkg::ValW-1:0] new_value_i,
  output logic                             rsp_valid_o,
  input  logic                             rsp_ready_i,
  output logic [1:0]                       status_o,
  output logic signed [plst_pkg::ValW-1:0] removed_value_o,
  output logic [plst_pkg::LenW-1:0]        list_length_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned ExtW = ((CntW > plst_pkg::LenW) ? CntW : plst_pkg::LenW) + 1;
  localparam int unsigned NSel = (Capacity < 31) ? Capacity : 31;

  logic                      accept;
  plst_pkg::plst_op_t        op;
  plst_pkg::plst_status_e    status;
  logic [CntW-1:0]           count_d;
  logic [CntW-1:0]           count_q;
  logic [ExtW-1:0]           count_ext;
  logic [plst_pkg::PosW-1:0] pos0;
  logic [plst_pkg::ValW-1:0] sel_val;
  logic [plst_pkg::ValW-1:0] removed;
  logic [plst_pkg::ValW-1:0] cell_val [Capacity];

  logic                      rsp_valid_q;
  logic [1:0]                status_q;
  logic [plst_pkg::ValW-1:0] removed_q;
  logic [plst_pkg::LenW-1:0] len_q;

  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign accept      = req_valid_i && req_ready_o;

  plst_ctrl #(
    .Capacity(Capacity)
  ) u_ctrl (
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .position_i (position_i),
    .new_value_i(new_value_i),
    .count_i    (count_q),
    .op_o       (op),
    .status_o   (status)
  );

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic [plst_pkg::ValW-1:0] left;
    logic [plst_pkg::ValW-1:0] right;
    if (g == 0) begin : g_first
      assign left = op.value;
    end else begin : g_mid_l
      assign left = cell_val[g-1];
    end
    if (g == Capacity - 1) begin : g_last
      assign right = cell_val[g];
    end else begin : g_mid_r
      assign right = cell_val[g+1];
    end
    plst_cell #(
      .Capacity(Capacity),
      .Idx     (g)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .left_i (left),
      .right_i(right),
      .value_o(cell_val[g])
    );
  end

  // removed entry, picked before the shift lands
  assign pos0 = position_i - plst_pkg::PosW'(1);

  always_comb begin
    sel_val = '0;
    for (int i = 0; i < NSel; i++) begin
      if (pos0 == plst_pkg::PosW'(i)) begin
        sel_val = sel_val | cell_val[i];
      end
    end
  end

  assign removed = op.del ? sel_val : '0;

  always_comb begin
    count_d = count_q;
    if (op.ins) begin
      count_d = count_q + CntW'(1);
    end else if (op.del) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign count_ext = ExtW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status;
      removed_q <= removed;
      len_q     <= count_ext[plst_pkg::LenW-1:0];
    end
  end

  assign rsp_valid_o     = rsp_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign list_length_o   = len_q;

  `PLST_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CntW'(Capacity), "list length above capacity")
  `PLST_ASSERT_IMP(a_full_only_at_cap, accept && (status == plst_pkg::StFull),
                   count_q == CntW'(Capacity), "full status below capacity")
  `PLST_ASSERT_NXT(a_insert_grows, op.ins,
                   count_q == CntW'($past(count_q) + CntW'(1)), "insert did not grow list")
  `PLST_ASSERT_IMP(a_ready_when_empty, !rsp_valid_q, req_ready_o, "not ready with empty response")

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import plst_pkg::*;

  localparam int Cap       = DefCapacity;
  localparam int IdleLimit = 5000;
  localparam int HoldLen   = 300;

  typedef struct {
    logic                   kind;
    logic [PosW-1:0]        pos;
    logic signed [ValW-1:0] val;
    bit                     drain;
  } list_req_t;

  typedef struct {
    plst_status_e           status;
    logic signed [ValW-1:0] removed;
    logic [LenW-1:0]        len;
  } list_rsp_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   req_valid_i = 1'b0;
  logic                   req_ready_o;
  logic                   req_type_i = ReqInsert;
  logic [PosW-1:0]        position_i = '0;
  logic signed [ValW-1:0] new_value_i = '0;
  logic                   rsp_valid_o;
  logic                   rsp_ready_i = 1'b0;
  logic [1:0]             status_o;
  logic signed [ValW-1:0] removed_value_o;
  logic [LenW-1:0]        list_length_o;

  list_req_t req_q[$];
  list_rsp_t rsp_q[$];
  list_req_t cur_req;

  logic signed [ValW-1:0] list_mem [Cap];
  int list_len = 0;
  int gen_len  = 0;

  int errors   = 0;
  int sent     = 0;
  int rsp_seen = 0;
  int n_ins_ok = 0;
  int n_del_ok = 0;
  int n_badpos = 0;
  int n_full   = 0;
  int max_len  = 0;

  positional_list_insert_delete #(
    .Capacity(Cap)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid_i),
    .req_ready_o    (req_ready_o),
    .req_type_i     (req_type_i),
    .position_i     (position_i),
    .new_value_i    (new_value_i),
    .rsp_valid_o    (rsp_valid_o),
    .rsp_ready_i    (rsp_ready_i),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .list_length_o  (list_length_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic list_rsp_t apply_list_request(list_req_t r);
    list_rsp_t rsp;
    int p;
    int k;
    rsp.status  = StOk;
    rsp.removed = '0;
    p = int'(r.pos);
    if (r.kind == ReqInsert) begin
      if (p < 1 || p > list_len + 1) begin
        rsp.status = StBadPos;
      end else if (list_len >= Cap) begin
        rsp.status = StFull;
      end else begin
        for (k = list_len; k >= p; k--) list_mem[k] = list_mem[k-1];
        list_mem[p-1] = r.val;
        list_len++;
      end
    end else begin
      if (p < 1 || p > list_len) begin
        rsp.status = StBadPos;
      end else begin
        rsp.removed = list_mem[p-1];
        for (k = p; k < list_len; k++) list_mem[k-1] = list_mem[k];
        list_len--;
      end
    end
    case (rsp.status)
      StOk:     if (r.kind == ReqInsert) n_ins_ok++; else n_del_ok++;
      StBadPos: n_badpos++;
      default:  n_full++;
    endcase
    if (list_len > max_len) max_len = list_len;
    rsp.len = LenW'(list_len);
    return rsp;
  endfunction

  task automatic queue_request(logic kind, int pos, logic signed [ValW-1:0] val, bit drain);
    list_req_t r;
    r.kind  = kind;
    r.pos   = PosW'(pos);
    r.val   = val;
    r.drain = drain;
    req_q.push_back(r);
    if (kind == ReqInsert) begin
      if (pos >= 1 && pos <= gen_len + 1 && gen_len < Cap) gen_len++;
    end else if (pos >= 1 && pos <= gen_len) begin
      gen_len--;
    end
  endtask

  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // request driver
  int  burst_left = 0;
  int  gap_left   = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic next_valid;
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
    end else begin
      if (req_valid_i && req_ready_o) begin
        rsp_q.push_back(apply_list_request(cur_req));
        sent++;
      end
      if (!(req_valid_i && !req_ready_o)) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0 && (!req_q[0].drain || rsp_q.size() == 0)) begin
          cur_req = req_q.pop_front();
          req_type_i  <= cur_req.kind;
          position_i  <= cur_req.pos;
          new_value_i <= cur_req.val;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left   = (sent >= 400 && sent < 600) ? 0 : $urandom_range(1, 6);
          end
        end
        req_valid_i <= next_valid;
      end
    end
  end

  // response monitor and ready pattern
  int  hold_cnt  = 0;
  bit  hold_done = 1'b0;
  int  run_cnt   = 0;
  bit  run_lvl   = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    list_rsp_t exp_rsp;
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
    end else begin
      if (rsp_valid_o && rsp_ready_i) begin
        rsp_seen++;
        if (rsp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected response status=%0d removed=%0d len=%0d",
                   $time, status_o, removed_value_o, list_length_o);
        end else begin
          exp_rsp = rsp_q.pop_front();
          if (status_o !== exp_rsp.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status, status_o);
          end
          if (removed_value_o !== exp_rsp.removed) begin
            errors++;
            $display("%0t: removed_value expected %0d actual %0d",
                     $time, exp_rsp.removed, removed_value_o);
          end
          if (list_length_o !== exp_rsp.len) begin
            errors++;
            $display("%0t: list_length expected %0d actual %0d",
                     $time, exp_rsp.len, list_length_o);
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_ready_i <= 1'b0;
      end else if (rsp_seen >= 900 && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt  = HoldLen;
        rsp_ready_i <= 1'b0;
      end else if (rsp_seen >= 400 && rsp_seen < 600) begin
        rsp_ready_i <= 1'b1;
      end else begin
        if (run_cnt == 0) begin
          run_lvl = !run_lvl;
          run_cnt = run_lvl ? $urandom_range(1, 12) : $urandom_range(1, 4);
        end else begin
          run_cnt--;
        end
        rsp_ready_i <= run_lvl;
      end
    end
  end

  // stall watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no request or response moved for %0d cycles", $time, IdleLimit);
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int ins_bias;
    int pos;
    int total;
    logic kind;

    // empty list, bad positions
    queue_request(ReqDelete, 1, 0, 1'b0);
    queue_request(ReqDelete, 0, 0, 1'b0);
    queue_request(ReqInsert, 0, 32'sh1234_5678, 1'b0);
    queue_request(ReqInsert, 2, 32'sh1234_5678, 1'b0);
    // fill to capacity at front, end and middle
    queue_request(ReqInsert, 1, 32'sh8000_0000, 1'b0);
    queue_request(ReqInsert, 1, 32'sh7fff_ffff, 1'b0);
    queue_request(ReqInsert, 3, -32'sd1, 1'b0);
    queue_request(ReqInsert, 2, 32'sd0, 1'b0);
    for (n = 4; n < Cap; n++) queue_request(ReqInsert, (n % 2) ? n + 1 : 2, pick_value(), 1'b0);
    // full list: position checked before capacity
    queue_request(ReqInsert, Cap + 1, 32'sd5, 1'b0);
    queue_request(ReqInsert, 1, 32'sd5, 1'b0);
    queue_request(ReqInsert, Cap + 2, 32'sd5, 1'b0);
    queue_request(ReqDelete, Cap + 1, 0, 1'b0);
    queue_request(ReqDelete, 31, 0, 1'b0);
    queue_request(ReqDelete, Cap, 0, 1'b0);
    queue_request(ReqDelete, 1, 0, 1'b0);
    queue_request(ReqDelete, 7, 0, 1'b0);

    ins_bias = 80;
    for (n = 0; n < 1700; n++) begin
      if (n % 120 == 0) ins_bias = (ins_bias > 50) ? 20 : 80;
      if ($urandom_range(0, 99) < 15) begin
        kind = $urandom_range(0, 1) ? ReqDelete : ReqInsert;
        pos  = $urandom_range(0, 31);
      end else begin
        kind = ($urandom_range(0, 99) < ins_bias) ? ReqInsert : ReqDelete;
        if (kind == ReqInsert) pos = $urandom_range(1, gen_len + 1);
        else pos = (gen_len == 0) ? 1 : $urandom_range(1, gen_len);
      end
      queue_request(kind, pos, pick_value(), n == 0 || n == 1300);
    end
    total = req_q.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rsp_seen < total) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("covered %0d requests: %0d inserts, %0d deletes, %0d bad position, %0d full",
             sent, n_ins_ok, n_del_ok, n_badpos, n_full);
    $display("longest list %0d of %0d entries, %0d mismatches", max_len, Cap, errors);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
